// ----- rtl/apas_pkg.sv -----
`timescale 1ns / 1ps

package apas_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int DIVISOR_W   = 16;
  localparam int PRESSURE_W  = 19;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // shared divider operand widths
  localparam int DIV_DVD_W   = 19;
  localparam int DIV_DVS_W   = 16;

  localparam int SAMPLES_DEF    = 20;
  localparam int UNDER_MARGIN   = 80;
  localparam int PRESSURE_SCALE = 100;

  // register select, taken from paddr bit 2
  localparam logic REG_ZERO_OFFSET  = 1'b0;
  localparam logic REG_GAIN_DIVISOR = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/apas_div.sv -----
`timescale 1ns / 1ps

module apas_div import apas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_DVD_W - 1);

  logic [DIV_DVS_W-1:0] rem_q;
  logic [DIV_DVS_W-1:0] dvs_q;
  logic [DIV_DVD_W-1:0] quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIV_DVS_W:0]   shifted;
  logic [DIV_DVS_W:0]   diff;
  logic                 ge;

  // one restoring step per cycle, msb first
  assign shifted = {rem_q, quo_q[DIV_DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
      quo_q <= {quo_q[DIV_DVD_W-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- rtl/apas_cfg.sv -----
`timescale 1ns / 1ps

module apas_cfg import apas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic [SAMPLE_W-1:0]   zero_offset_o,
  output logic [DIVISOR_W-1:0]  gain_divisor_o
);

  logic [SAMPLE_W-1:0]  zero_offset_q;
  logic [DIVISOR_W-1:0] gain_divisor_q;
  logic                 wr_en;
  logic [DIVISOR_W-1:0] gain_wr;

  assign wr_en   = psel && penable && pwrite;
  assign gain_wr = pwdata[DIVISOR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q  <= '0;
      gain_divisor_q <= DIVISOR_W'(1);
    end else if (wr_en) begin
      case (paddr[2])
        REG_ZERO_OFFSET:  zero_offset_q <= pwdata[SAMPLE_W-1:0];
        REG_GAIN_DIVISOR: gain_divisor_q <= (gain_wr == '0) ? DIVISOR_W'(1) : gain_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ZERO_OFFSET:  prdata = APB_DATA_W'(zero_offset_q);
      REG_GAIN_DIVISOR: prdata = APB_DATA_W'(gain_divisor_q);
      default:          prdata = '0;
    endcase
  end

  assign zero_offset_o  = zero_offset_q;
  assign gain_divisor_o = gain_divisor_q;

endmodule

// ----- rtl/averaged_adc_pressure_scaler.sv -----
`timescale 1ns / 1ps

// Block-averaging pressure scaler. Converter samples arrive one beat at a time
// and are summed; every SAMPLES_PER_READING samples the block emits one result
// beat carrying the truncated group mean, an under-range flag (mean + 80 at or
// below zero_offset) and pressure = 100 * max(mean - zero_offset, 0) /
// gain_divisor, truncated, forced to 0 under range. A sample that does not
// close a group causes no stall of its own. Accepting the sample that closes
// a group raises in_stall_o until its result reaches the output register; the
// single shared radix-2 divider runs once for the mean (sum / group size) and
// once for the scaled pressure, one quotient bit per cycle on a 19-bit dividend.
// A finished result sits in an output register, so sampling of the next group
// goes on while that beat waits to be taken. Registers over APB: zero_offset
// at 0x0 (12 bits, reset 0), gain_divisor at 0x4 (16 bits, reset 1; a write of
// 0 stores 1). Write registers only while no group completion is in flight.

module averaged_adc_pressure_scaler import apas_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   raw_sample_i,

  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PRESSURE_W-1:0] pressure_o,
  output logic [SAMPLE_W-1:0]   mean_sample_o,
  output logic                  under_range_o,

  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // group counter and sum sized from the group length
  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;  // taking samples
  localparam logic [2:0] ST_MEAN  = 3'd1;  // divider forms the mean
  localparam logic [2:0] ST_CALC  = 3'd2;  // offset check, launch pressure divide
  localparam logic [2:0] ST_SCALE = 3'd3;  // divider forms the pressure
  localparam logic [2:0] ST_OUT   = 3'd4;  // waiting for the output register

  logic [2:0]            state_q, state_d;
  logic [SUM_W-1:0]      sum_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [SUM_W-1:0]      acc_sum;
  logic                  in_accept;
  logic                  slot_free;

  logic [SAMPLE_W-1:0]   mean_q;
  logic                  fault_q;
  logic [PRESSURE_W-1:0] pres_q;

  logic [PRESSURE_W-1:0] out_pressure_q;
  logic [SAMPLE_W-1:0]   out_mean_q;
  logic                  out_under_q;
  logic                  out_valid_q;

  logic [SAMPLE_W-1:0]   zero_offset;
  logic [DIVISOR_W-1:0]  gain_divisor;
  logic                  fault;
  logic [SAMPLE_W-1:0]   delta;
  logic [DIV_DVD_W-1:0]  scaled;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  apas_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .zero_offset_o  (zero_offset),
    .gain_divisor_o (gain_divisor)
  );

  apas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pready     = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign acc_sum    = sum_q + SUM_W'(raw_sample_i);

  // under range when mean + 80 <= offset; otherwise clamp the difference at 0
  assign fault  = ({1'b0, mean_q} + (SAMPLE_W + 1)'(UNDER_MARGIN)) <= {1'b0, zero_offset};
  assign delta  = (mean_q > zero_offset) ? (mean_q - zero_offset) : '0;
  // delta is 0 under range, so the divide yields pressure 0 as well
  assign scaled = DIV_DVD_W'(delta) * DIV_DVD_W'(PRESSURE_SCALE);

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_DVD_W'(acc_sum);
    div_req.divisor  = DIV_DVS_W'(SAMPLES_PER_READING);
    case (state_q)
      ST_IDLE: begin
        if (in_accept && cnt_q == CNT_LAST) begin
          div_req.start = 1'b1;
          state_d       = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) state_d = ST_CALC;
      end
      ST_CALC: begin
        div_req.start    = 1'b1;
        div_req.dividend = scaled;
        div_req.divisor  = DIV_DVS_W'(gain_divisor);
        state_d          = ST_SCALE;
      end
      ST_SCALE: begin
        if (div_rsp.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        if (cnt_q == CNT_LAST) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= acc_sum;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEAN && div_rsp.done) mean_q <= div_rsp.quotient[SAMPLE_W-1:0];
    if (state_q == ST_CALC) fault_q <= fault;
    if (state_q == ST_SCALE && div_rsp.done) pres_q <= div_rsp.quotient[PRESSURE_W-1:0];
    if (state_q == ST_OUT && slot_free) begin
      out_pressure_q <= pres_q;
      out_mean_q     <= mean_q;
      out_under_q    <= fault_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pressure_o    = out_pressure_q;
  assign mean_sample_o = out_mean_q;
  assign under_range_o = out_under_q;

`ifndef SYNTH
  // the shared divider is never relaunched mid-run
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // an under-range result always carries zero pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && under_range_o) |-> (pressure_o == '0))
    else $error("under-range result with nonzero pressure");

  // the divisor register never holds zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) gain_divisor != '0)
    else $error("gain divisor is zero");

  // a divide finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_MEAN || state_q == ST_SCALE))
    else $error("divider result with no consumer");
`endif

endmodule

// ----- tb/averaged_adc_pressure_scaler_tb.sv -----
`timescale 1ns / 1ps

module averaged_adc_pressure_scaler_tb;
  import apas_pkg::*;

  // group size follows the block's default parameter
  localparam int GROUP         = SAMPLES_DEF;
  localparam int SAMPLE_MAX    = 2 ** SAMPLE_W - 1;
  localparam int DIVISOR_MAX   = 2 ** DIVISOR_W - 1;
  localparam int IDLE_PCT      = 34;
  localparam int ITEM_TARGET   = 1550;
  localparam int QUIET_GROUPS  = 10;
  // a group close runs two divides in the shared divider
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS   = 40;
  localparam int TIMEOUT_NS    = 4_000_000;

  // register byte addresses, bit 2 picks the register
  localparam logic [APB_ADDR_W-1:0] ADDR_ZERO_OFFSET  = {REG_ZERO_OFFSET, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_GAIN_DIVISOR = {REG_GAIN_DIVISOR, 2'b00};

  // one reading as the block should emit it
  typedef struct packed {
    logic [PRESSURE_W-1:0] pressure;
    logic [SAMPLE_W-1:0]   mean_sample;
    logic                  under_range;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   raw_sample_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [PRESSURE_W-1:0] pressure_o;
  logic [SAMPLE_W-1:0]   mean_sample_o;
  logic                  under_range_o;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // calibration as the block should hold it
  logic [SAMPLE_W-1:0]   zero_offset_cfg  = '0;
  logic [DIVISOR_W-1:0]  gain_divisor_cfg = DIVISOR_W'(1);

  // group in progress: running sum and number of samples taken so far
  logic [17:0]           group_sum  = '0;
  logic [5:0]            group_fill = '0;

  reading_t              expected_readings[$];

  // when low, neither side inserts bubbles
  bit                    idle_on = 1'b1;

  int                    mismatch_count = 0;
  int                    sample_total   = 0;
  int                    reading_total  = 0;
  int                    under_total    = 0;
  int                    setting_total  = 0;

  averaged_adc_pressure_scaler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_sample_i  (raw_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pressure_o    (pressure_o),
    .mean_sample_o (mean_sample_o),
    .under_range_o (under_range_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // fold one accepted sample into the running group; a closing sample
  // yields the reading the block owes us
  task automatic fold_sample(input logic [SAMPLE_W-1:0] value);
    int       mean;
    int       delta;
    reading_t want;
    group_sum  = group_sum + 18'(value);
    group_fill = group_fill + 6'd1;
    if (group_fill == GROUP) begin
      mean       = int'(group_sum) / GROUP;
      group_sum  = '0;
      group_fill = '0;
      delta      = 0;
      want.under_range = 1'b0;
      // fault when the mean sits at least the margin below the zero point;
      // inside the margin the count clamps to zero instead
      if (mean + UNDER_MARGIN <= int'(zero_offset_cfg)) begin
        want.under_range = 1'b1;
      end else if (mean > int'(zero_offset_cfg)) begin
        delta = mean - int'(zero_offset_cfg);
      end
      want.mean_sample = mean[SAMPLE_W-1:0];
      want.pressure    = want.under_range ? '0 :
                         PRESSURE_W'((PRESSURE_SCALE * delta) / int'(gain_divisor_cfg));
      expected_readings.push_back(want);
    end
  endtask

  // result side: random stall, driven on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // result side: every beat taken is checked against the oldest reading owed
  always @(posedge clk_i) begin : check_output
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reading_total++;
      if (under_range_o === 1'b1) begin
        under_total++;
      end
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("reading beat with none pending (mean %0d)",
                                  mean_sample_o));
      end else begin
        want = expected_readings.pop_front();
        if (pressure_o !== want.pressure) begin
          report_mismatch($sformatf("pressure got %0d want %0d (mean %0d)",
                                    pressure_o, want.pressure, want.mean_sample));
        end
        if (mean_sample_o !== want.mean_sample) begin
          report_mismatch($sformatf("mean got %0d want %0d",
                                    mean_sample_o, want.mean_sample));
        end
        if (under_range_o !== want.under_range) begin
          report_mismatch($sformatf("under_range got %b want %b (mean %0d)",
                                    under_range_o, want.under_range, want.mean_sample));
        end
      end
    end
  end

  // one sample beat; starts and ends on a falling edge, valid stays up on
  // return so back-to-back beats need no bubble
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_sample(value);
    sample_total++;
    @(negedge clk_i);
  endtask

  // sender holds off until every owed reading is back, then lets the
  // divider settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // only the low bits land; a zero divisor is stored as one
    if (addr[2] == REG_ZERO_OFFSET) begin
      zero_offset_cfg = data[SAMPLE_W-1:0];
    end else begin
      gain_divisor_cfg = (data[DIVISOR_W-1:0] == '0) ? DIVISOR_W'(1) : data[DIVISOR_W-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      report_mismatch($sformatf("register 0x%0h read 0x%0h want 0x%0h", addr, prdata, want));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // new calibration while the block is idle; junk above the register width
  // must be dropped, then both registers are read back
  task automatic set_calibration(input logic [SAMPLE_W-1:0]  zero,
                                 input logic [DIVISOR_W-1:0] gain);
    logic [APB_DATA_W-1:0] word;
    wait_drained();
    word = $urandom();
    word[SAMPLE_W-1:0] = zero;
    apb_write(ADDR_ZERO_OFFSET, word);
    word = $urandom();
    word[DIVISOR_W-1:0] = gain;
    apb_write(ADDR_GAIN_DIVISOR, word);
    apb_read_check(ADDR_ZERO_OFFSET, APB_DATA_W'(zero_offset_cfg));
    apb_read_check(ADDR_GAIN_DIVISOR, APB_DATA_W'(gain_divisor_cfg));
    setting_total++;
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX)));
    end
  endtask

  // a full group whose truncated mean is exactly the level: a few samples
  // carry one extra count (below one full step), and pairs are spread apart
  // without moving the sum
  task automatic send_level_group(input int level);
    logic [SAMPLE_W-1:0] vals [GROUP];
    int spill;
    int lim;
    int d;
    if (level < 0) level = 0;
    if (level > SAMPLE_MAX) level = SAMPLE_MAX;
    spill = (level < SAMPLE_MAX) ? $urandom_range(GROUP - 1) : 0;
    for (int i = 0; i < GROUP; i++) begin
      vals[i] = SAMPLE_W'(level + ((i < spill) ? 1 : 0));
    end
    for (int i = 0; i + 1 < GROUP; i += 2) begin
      lim = SAMPLE_MAX - int'(vals[i]);
      if (int'(vals[i+1]) < lim) lim = int'(vals[i+1]);
      d = $urandom_range(lim);
      vals[i]   = vals[i] + SAMPLE_W'(d);
      vals[i+1] = vals[i+1] - SAMPLE_W'(d);
    end
    for (int i = 0; i < GROUP; i++) begin
      send_sample(vals[i]);
    end
  endtask

  // mean levels clustered on the fault margin and the zero point
  function automatic int pick_level();
    int z;
    z = int'(zero_offset_cfg);
    case ($urandom_range(7))
      0:       return z - UNDER_MARGIN - 1;
      1:       return z - UNDER_MARGIN;
      2:       return z - UNDER_MARGIN + 1;
      3:       return z - 1;
      4:       return z;
      5:       return z + 1;
      6:       return ($urandom_range(1)) ? SAMPLE_MAX : 0;
      default: return $urandom_range(SAMPLE_MAX);
    endcase
  endfunction

  // registers come out of reset at zero offset and unit divisor
  task automatic test_register_reset();
    apb_read_check(ADDR_ZERO_OFFSET, APB_DATA_W'(0));
    apb_read_check(ADDR_GAIN_DIVISOR, APB_DATA_W'(1));
  endtask

  // all ones gives the largest pressure, all zeros a clean zero reading
  task automatic test_full_scale();
    set_calibration('0, DIVISOR_W'(1));
    for (int i = 0; i < GROUP; i++) send_sample(SAMPLE_W'(SAMPLE_MAX));
    for (int i = 0; i < GROUP; i++) send_sample('0);
  endtask

  // fault at the far end, then both sides of the margin edge
  task automatic test_under_range();
    set_calibration(SAMPLE_W'(SAMPLE_MAX), DIVISOR_W'(1));
    for (int i = 0; i < GROUP; i++) send_sample('0);
    send_level_group(SAMPLE_MAX - UNDER_MARGIN);
    send_level_group(SAMPLE_MAX - UNDER_MARGIN + 1);
  endtask

  // writing a zero divisor must leave it at one
  task automatic test_zero_divisor_write();
    set_calibration(SAMPLE_W'(100), '0);
    send_level_group(SAMPLE_MAX);
    set_calibration(SAMPLE_W'(0), DIVISOR_W'(DIVISOR_MAX));
    send_level_group(SAMPLE_MAX);
  endtask

  // long run with no bubbles on either side
  task automatic test_quiet_burst();
    set_calibration(SAMPLE_W'($urandom_range(SAMPLE_MAX)), DIVISOR_W'($urandom_range(1, 50)));
    idle_on = 1'b0;
    for (int g = 0; g < QUIET_GROUPS; g++) begin
      if (g % 2 == 0) send_noise(GROUP);
      else send_level_group(pick_level());
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  // phases of groups under rotating calibration; most groups are aligned
  // level groups, the rest plain noise or a torn partial group
  task automatic test_random_phases();
    int phase;
    int groups;
    int pick;
    phase = 0;
    while (sample_total < ITEM_TARGET) begin
      case (phase % 6)
        0: set_calibration(SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                           DIVISOR_W'($urandom_range(1, 20)));
        1: set_calibration('0, DIVISOR_W'(1));
        2: set_calibration(SAMPLE_W'(SAMPLE_MAX), DIVISOR_W'(DIVISOR_MAX));
        3: set_calibration(SAMPLE_W'($urandom_range(SAMPLE_MAX)), '0);
        4: set_calibration(SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                           DIVISOR_W'($urandom_range(DIVISOR_MAX)));
        default: set_calibration(SAMPLE_W'($urandom_range(200)),
                                 DIVISOR_W'($urandom_range(1, 500)));
      endcase
      groups = $urandom_range(3, 8);
      for (int g = 0; g < groups && sample_total < ITEM_TARGET; g++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // realign first so the level group closes on its own
          if (group_fill != 0) send_noise(GROUP - int'(group_fill));
          send_level_group(pick_level());
        end else if (pick < 85) begin
          send_noise(GROUP);
        end else begin
          send_noise($urandom_range(1, GROUP - 1));
        end
      end
      phase++;
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_reset();
    test_full_scale();
    test_under_range();
    test_zero_divisor_write();
    test_quiet_burst();
    test_random_phases();

    $display("ran %0d samples into %0d readings across %0d calibration settings",
             sample_total, reading_total, setting_total);
    $display("%0d readings flagged under range, %0d mismatches", under_total, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
